/* hw/rtl/rrtt_pkg.sv */
// Shared types and constants of the request retry/timeout table.
`default_nettype none

package rrtt_pkg;

  localparam int unsigned DEPTH_DEFAULT     = 1024;
  localparam int unsigned TIME_BITS_DEFAULT = 48;

  localparam int unsigned ID_W      = 10;
  localparam int unsigned NOW_W     = 48;
  localparam int unsigned TC_W      = 11;
  localparam int unsigned RETRY_W   = 5;
  localparam int unsigned MAXR_W    = 4;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;

  // output tdata layout
  localparam int unsigned OUT_TIDX_LSB  = 10;
  localparam int unsigned OUT_RETRY_LSB = 20;

  localparam logic [CFG_W-1:0]   BASE_TIMEOUT_RST   = 32'd20000;
  localparam logic [CFG_W-1:0]   MAX_TIMEOUT_RST    = 32'd500000;
  localparam logic [MAXR_W-1:0]  MAX_RETRIES_RST    = 4'd3;
  localparam logic [TC_W-1:0]    TEMPLATE_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_ISSUE    = 2'd0,
    FUNC_COMPLETE = 2'd1,
    FUNC_CHECK    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RESEND  = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_DROP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_BASE_TIMEOUT   = 2'd0,
    REG_MAX_TIMEOUT    = 2'd1,
    REG_MAX_RETRIES    = 2'd2,
    REG_TEMPLATE_COUNT = 2'd3
  } reg_e;

endpackage

`default_nettype wire

/* hw/rtl/rrtt_mod.sv */
// Iterative remainder unit: request id modulo template count.
`default_nettype none

module rrtt_mod (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rrtt_pkg::ID_W-1:0]   dividend_i,
  input  wire logic [rrtt_pkg::TC_W-1:0]   divisor_i,
  output logic      [rrtt_pkg::ID_W-1:0]   rem_o
);

  localparam int unsigned BITS_PER_CYCLE = 5;
  localparam int unsigned NUM_CYCLES = rrtt_pkg::ID_W / BITS_PER_CYCLE;
  localparam int unsigned CNT_W = $clog2(NUM_CYCLES + 1);

  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [rrtt_pkg::ID_W-1:0]     dvd_q, dvd_d;
  logic [rrtt_pkg::TC_W-1:0]     dvs_q;
  logic [rrtt_pkg::TC_W:0]       rem_q, rem_d;

  // restoring division, several quotient bits per cycle; the remainder
  // stays below the divisor, a zero divisor is forced to zero at the output
  always_comb begin
    logic [rrtt_pkg::TC_W:0]   r;
    logic [rrtt_pkg::ID_W-1:0] d;
    r = rem_q;
    d = dvd_q;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      r = {r[rrtt_pkg::TC_W-1:0], d[rrtt_pkg::ID_W-1]};
      d = {d[rrtt_pkg::ID_W-2:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r = r - {1'b0, dvs_q};
      end
    end
    rem_d = r;
    dvd_d = d;
    cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_CYCLES);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign rem_o = (dvs_q == '0) ? '0 : rem_q[rrtt_pkg::ID_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/request_retry_timeout_table.sv */
// Top level of the request retry/timeout table with exponential backoff.
//
//  channel    dir  handshake          payload
//  s_axis     in   tvalid/tready      tuser: func; tdata: req_id, now_us, tx_accepted
//  m_axis     out  tvalid/tready      tuser: action; tdata: req id out, template_index,
//                                     retries
//  apb        in   psel/penable       registers at 0x0, 0x4, 0x8, 0xC
//
// A request goes through accept, table read, elapsed time and backoff limit,
// then compare and write back. One request is in flight at a time.
// The next request is taken while the previous result still waits on m_axis;
// a result not taken holds the write-back cycle until the output slot frees.
// After reset the table is swept to zero, one entry a cycle, with s_axis_tready
// low until the sweep ends; configuration writes are taken throughout.
// The modulo for the template index runs alongside in rrtt_mod, 5 bits a cycle.
`default_nettype none

module request_retry_timeout_table #(
  parameter int unsigned TABLE_DEPTH = rrtt_pkg::DEPTH_DEFAULT,
  parameter int unsigned TIME_BITS   = rrtt_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [9:0] req_id, [57:10] now_us, [58] tx_accepted
  input  wire logic [rrtt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [9:0] req id out, [19:10] template_index, [24:20] retries
  output logic      [rrtt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [1:0] action
  output logic      [1:0]                        m_axis_tuser,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rrtt_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [rrtt_pkg::CFG_W-1:0]        pwdata,
  output logic      [rrtt_pkg::CFG_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic [TIME_BITS-1:0]          start;
    logic [rrtt_pkg::RETRY_W-1:0]  retries;
    logic                          done;
    logic                          expired;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_UPDATE
  } state_e;

  // configuration
  logic [rrtt_pkg::CFG_W-1:0]   base_q, max_q;
  logic [rrtt_pkg::MAXR_W-1:0]  max_retries_q;
  logic [rrtt_pkg::TC_W-1:0]    tc_q;
  logic                         cfg_we;
  rrtt_pkg::reg_e               cfg_sel;

  state_e                       state_q;
  logic [IDX_W-1:0]             clr_addr_q;
  logic                         s_acc;

  // request held across its cycles
  logic [1:0]                   func_q;
  logic [rrtt_pkg::ID_W-1:0]    id_q;
  logic [IDX_W-1:0]             addr_q;
  logic                         in_range_q;
  logic [TIME_BITS-1:0]         now_q;
  logic                         acc_q;
  logic [31:0]                  id_ext;
  logic [63:0]                  now_ext;

  // table
  entry_t                       table_mem [TABLE_DEPTH];
  entry_t                       rdata_q;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  entry_t                       mem_wdata;

  // elapsed time and limit
  logic [TIME_BITS-1:0]         elapsed_q, elapsed_d;
  logic [rrtt_pkg::CFG_W-1:0]   limit_q, limit_d;
  logic [63:0]                  lim_wide;
  logic [rrtt_pkg::RETRY_W-1:0] shamt;

  // write-back decision
  logic                         out_free;
  logic                         hit;
  logic                         upd_we;
  entry_t                       upd_entry;
  rrtt_pkg::action_e            upd_action;
  logic [rrtt_pkg::RETRY_W-1:0] upd_retries;
  logic [rrtt_pkg::ID_W-1:0]    tidx;

  // output slot
  logic                         out_valid_q;
  logic [1:0]                   out_action_q;
  logic [rrtt_pkg::ID_W-1:0]    out_id_q;
  logic [rrtt_pkg::ID_W-1:0]    out_tidx_q;
  logic [rrtt_pkg::RETRY_W-1:0] out_retries_q;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_sel = rrtt_pkg::reg_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_sel)
      rrtt_pkg::REG_BASE_TIMEOUT:   prdata = base_q;
      rrtt_pkg::REG_MAX_TIMEOUT:    prdata = max_q;
      rrtt_pkg::REG_MAX_RETRIES:    prdata = 32'(max_retries_q);
      rrtt_pkg::REG_TEMPLATE_COUNT: prdata = 32'(tc_q);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= rrtt_pkg::BASE_TIMEOUT_RST;
      max_q         <= rrtt_pkg::MAX_TIMEOUT_RST;
      max_retries_q <= rrtt_pkg::MAX_RETRIES_RST;
      tc_q          <= rrtt_pkg::TEMPLATE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        rrtt_pkg::REG_BASE_TIMEOUT:   base_q        <= pwdata;
        rrtt_pkg::REG_MAX_TIMEOUT:    max_q         <= pwdata;
        rrtt_pkg::REG_MAX_RETRIES:    max_retries_q <= pwdata[rrtt_pkg::MAXR_W-1:0];
        rrtt_pkg::REG_TEMPLATE_COUNT: tc_q          <= pwdata[rrtt_pkg::TC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign id_ext        = 32'(s_axis_tdata[rrtt_pkg::ID_W-1:0]);
  assign now_ext       = 64'(s_axis_tdata[rrtt_pkg::ID_W +: rrtt_pkg::NOW_W]);

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      func_q     <= s_axis_tuser;
      id_q       <= s_axis_tdata[rrtt_pkg::ID_W-1:0];
      addr_q     <= id_ext[IDX_W-1:0];
      in_range_q <= id_ext < 32'(TABLE_DEPTH);
      now_q      <= now_ext[TIME_BITS-1:0];
      acc_q      <= s_axis_tdata[rrtt_pkg::ID_W + rrtt_pkg::NOW_W];
    end
  end

  rrtt_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_acc),
    .dividend_i (s_axis_tdata[rrtt_pkg::ID_W-1:0]),
    .divisor_i  (tc_q),
    .rem_o      (tidx)
  );

  // ---------------------------------------------------------------- table
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = upd_entry;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (state_q == ST_UPDATE && out_free) begin
      mem_we = upd_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rdata_q <= table_mem[addr_q];
    end
  end

  // ---------------------------------------------------------------- calc
  always_comb begin
    elapsed_d = (now_q >= rdata_q.start) ? now_q - rdata_q.start : '0;
    shamt     = rdata_q.retries - rrtt_pkg::RETRY_W'(1);
    lim_wide  = (rdata_q.retries == '0) ? 64'(base_q) : (64'(base_q) << shamt);
    limit_d   = (lim_wide > 64'(max_q)) ? max_q : lim_wide[rrtt_pkg::CFG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      elapsed_q <= elapsed_d;
      limit_q   <= limit_d;
    end
  end

  // ---------------------------------------------------------------- update
  assign out_free = !out_valid_q || m_axis_tready;
  assign hit      = 64'(elapsed_q) >= 64'(limit_q);

  always_comb begin
    upd_we      = 1'b0;
    upd_entry   = rdata_q;
    upd_action  = rrtt_pkg::ACT_NONE;
    if (in_range_q) begin
      unique case (func_q)
        rrtt_pkg::FUNC_ISSUE: begin
          upd_we            = 1'b1;
          upd_entry.start   = now_q;
          upd_entry.retries = '0;
          upd_entry.done    = !acc_q;
          upd_entry.expired = 1'b0;
          if (!acc_q) begin
            upd_action = rrtt_pkg::ACT_DROP;
          end
        end
        rrtt_pkg::FUNC_COMPLETE: begin
          upd_we         = 1'b1;
          upd_entry.done = 1'b1;
        end
        rrtt_pkg::FUNC_CHECK: begin
          if (!rdata_q.done && !rdata_q.expired && hit) begin
            if (rdata_q.retries > {1'b0, max_retries_q}) begin
              upd_we            = 1'b1;
              upd_entry.expired = 1'b1;
              upd_action        = rrtt_pkg::ACT_TIMEOUT;
            end else if (acc_q) begin
              upd_we          = 1'b1;
              upd_entry.start = now_q;
              if (rdata_q.retries != '1) begin
                upd_entry.retries = rdata_q.retries + rrtt_pkg::RETRY_W'(1);
              end
              upd_action = rrtt_pkg::ACT_RESEND;
            end
          end
        end
        default: ;
      endcase
    end
    upd_retries = in_range_q ? upd_entry.retries : '0;
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      out_valid_q   <= 1'b0;
      out_action_q  <= '0;
      out_id_q      <= '0;
      out_tidx_q    <= '0;
      out_retries_q <= '0;
    end else begin
      if (state_q == ST_UPDATE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + IDX_W'(1);
          if (clr_addr_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_acc) begin
            state_q <= ST_READ;
          end
        end
        ST_READ:  state_q <= ST_CALC;
        ST_CALC:  state_q <= ST_UPDATE;
        ST_UPDATE: begin
          if (out_free) begin
            out_action_q  <= upd_action;
            out_id_q      <= id_q;
            out_tidx_q    <= tidx;
            out_retries_q <= upd_retries;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_action_q;
  assign m_axis_tdata  = rrtt_pkg::OUT_DATA_W'({out_retries_q, out_tidx_q, out_id_q});

endmodule

`default_nettype wire

/* hw/rtl/rrtt_chk.sv */
// Port-level assertions for the request retry/timeout table, bound to the top.
`default_nettype none

module rrtt_chk (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic [rrtt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  wire logic [1:0]                       m_axis_tuser
);

  logic [rrtt_pkg::RETRY_W-1:0] out_retries;

  assign out_retries = m_axis_tdata[rrtt_pkg::OUT_RETRY_LSB +: rrtt_pkg::RETRY_W];

  // one request in flight: no new request right after one was taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // a dropped issue leaves the entry with no retries
  a_drop_retries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == rrtt_pkg::ACT_DROP |-> out_retries == '0)
    else $error("drop reported with nonzero retry count");

  // a resend always counts at least one retry
  a_resend_retries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == rrtt_pkg::ACT_RESEND |-> out_retries != '0)
    else $error("resend reported with zero retry count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind request_retry_timeout_table rrtt_chk u_rrtt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* bench/request_retry_timeout_table_tb.sv */
// Testbench for the request retry/timeout table: stream traffic checked against a table predictor.
`default_nettype none

module request_retry_timeout_table_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 5000;

  typedef struct packed {
    logic [1:0]                   action;
    logic [rrtt_pkg::ID_W-1:0]    req_id;
    logic [rrtt_pkg::ID_W-1:0]    template_index;
    logic [rrtt_pkg::RETRY_W-1:0] retries;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rrtt_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rrtt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]                      m_axis_tuser;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [rrtt_pkg::PADDR_W-1:0]    paddr = '0;
  logic [rrtt_pkg::CFG_W-1:0]      pwdata = '0;
  logic [rrtt_pkg::CFG_W-1:0]      prdata;
  logic                            pready;

  // predictor copy of the configuration and the table
  logic [rrtt_pkg::CFG_W-1:0]   cfg_base_timeout;
  logic [rrtt_pkg::CFG_W-1:0]   cfg_max_timeout;
  logic [rrtt_pkg::MAXR_W-1:0]  cfg_max_retries;
  logic [rrtt_pkg::TC_W-1:0]    cfg_template_count;
  logic [rrtt_pkg::NOW_W-1:0]   start_stamp [rrtt_pkg::DEPTH_DEFAULT];
  logic [rrtt_pkg::RETRY_W-1:0] retry_tally [rrtt_pkg::DEPTH_DEFAULT];
  logic                         done_mark   [rrtt_pkg::DEPTH_DEFAULT];
  logic                         expired_mark[rrtt_pkg::DEPTH_DEFAULT];

  table_result_t pending_results[$];
  int unsigned   error_count = 0;
  int unsigned   src_idle_pct = 31;
  int unsigned   sink_idle_pct = 31;
  int unsigned   sink_hold = 0;
  logic [rrtt_pkg::NOW_W-1:0] traffic_time;

  request_retry_timeout_table DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic logic [63:0] backoff_limit(logic [rrtt_pkg::RETRY_W-1:0] r);
    logic [63:0] lim;
    lim = {32'd0, cfg_base_timeout};
    if (r != '0) lim = lim << (r - 5'd1);
    if (lim > {32'd0, cfg_max_timeout}) lim = {32'd0, cfg_max_timeout};
    return lim;
  endfunction

  function automatic table_result_t predict_request(logic [1:0] func,
                                                    logic [rrtt_pkg::ID_W-1:0] id,
                                                    logic [rrtt_pkg::NOW_W-1:0] now,
                                                    logic acc);
    table_result_t res;
    logic [rrtt_pkg::NOW_W-1:0] elapsed;
    logic [rrtt_pkg::RETRY_W-1:0] r;
    res.action = rrtt_pkg::ACT_NONE;
    res.req_id = id;
    res.template_index = (cfg_template_count == '0) ? '0
                         : rrtt_pkg::ID_W'({1'b0, id} % cfg_template_count);
    case (func)
      rrtt_pkg::FUNC_ISSUE: begin
        start_stamp[id] = now;
        retry_tally[id] = '0;
        done_mark[id] = 1'b0;
        expired_mark[id] = 1'b0;
        if (!acc) begin
          done_mark[id] = 1'b1;
          res.action = rrtt_pkg::ACT_DROP;
        end
      end
      rrtt_pkg::FUNC_COMPLETE: done_mark[id] = 1'b1;
      rrtt_pkg::FUNC_CHECK: begin
        if (!done_mark[id] && !expired_mark[id]) begin
          elapsed = (now >= start_stamp[id]) ? now - start_stamp[id] : '0;
          r = retry_tally[id];
          if ({16'd0, elapsed} >= backoff_limit(r)) begin
            if (r > {1'b0, cfg_max_retries}) begin
              expired_mark[id] = 1'b1;
              res.action = rrtt_pkg::ACT_TIMEOUT;
            end else if (acc) begin
              if (r < 5'd31) retry_tally[id] = r + 5'd1;
              start_stamp[id] = now;
              res.action = rrtt_pkg::ACT_RESEND;
            end
          end
        end
      end
      default: ;
    endcase
    res.retries = retry_tally[id];
    return res;
  endfunction

  // one APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(logic wr, logic [rrtt_pkg::PADDR_W-1:0] addr,
                            logic [rrtt_pkg::CFG_W-1:0] wdata,
                            output logic [rrtt_pkg::CFG_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_register(rrtt_pkg::reg_e idx, logic [rrtt_pkg::CFG_W-1:0] value);
    logic [rrtt_pkg::CFG_W-1:0] rdata;
    logic [rrtt_pkg::CFG_W-1:0] stored;
    apb_access(1'b1, {idx, 2'b00}, value, rdata);
    case (idx)
      rrtt_pkg::REG_BASE_TIMEOUT: begin cfg_base_timeout = value; stored = value; end
      rrtt_pkg::REG_MAX_TIMEOUT:  begin cfg_max_timeout = value; stored = value; end
      rrtt_pkg::REG_MAX_RETRIES: begin
        cfg_max_retries = value[rrtt_pkg::MAXR_W-1:0];
        stored = {28'd0, value[rrtt_pkg::MAXR_W-1:0]};
      end
      default: begin
        cfg_template_count = value[rrtt_pkg::TC_W-1:0];
        stored = {21'd0, value[rrtt_pkg::TC_W-1:0]};
      end
    endcase
    apb_access(1'b0, {idx, 2'b00}, '0, rdata);
    if (rdata !== stored) report_mismatch("register readback", rdata, stored);
  endtask

  task automatic set_config(logic [31:0] base, logic [31:0] maxt, logic [3:0] maxr,
                            logic [10:0] tc);
    write_register(rrtt_pkg::REG_BASE_TIMEOUT, base);
    write_register(rrtt_pkg::REG_MAX_TIMEOUT, maxt);
    write_register(rrtt_pkg::REG_MAX_RETRIES, {28'd0, maxr});
    write_register(rrtt_pkg::REG_TEMPLATE_COUNT, {21'd0, tc});
  endtask

  task automatic send_request(logic [1:0] func, logic [rrtt_pkg::ID_W-1:0] id,
                              logic [rrtt_pkg::NOW_W-1:0] now, logic acc);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {5'd0, acc, now, id};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results = {pending_results, predict_request(func, id, now, acc)};
  endtask

  // stop offering, let every result come back, then give the pipeline time to settle
  task automatic wait_idle();
    int unsigned n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && n < DRAIN_CYCLES) begin
      @(posedge clk_i);
      n++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results missing", pending_results.size(), 0);
      pending_results.delete();
    end
  endtask

  // mostly issue/check sequences on a small pool of ids, with noise around them
  task automatic run_traffic(int count, logic [63:0] step_max);
    logic [rrtt_pkg::ID_W-1:0]  pool[8];
    logic [rrtt_pkg::ID_W-1:0]  id;
    logic [1:0]                 func;
    logic [rrtt_pkg::NOW_W-1:0] now;
    logic [63:0]                adv;
    int pick;
    for (int k = 0; k < 8; k++) pool[k] = rrtt_pkg::ID_W'($urandom_range(0, 1023));
    for (int k = 0; k < count; k++) begin
      id = ($urandom_range(99) < 85) ? pool[$urandom_range(0, 7)]
                                     : rrtt_pkg::ID_W'($urandom_range(0, 1023));
      pick = $urandom_range(99);
      if (pick < 12) func = rrtt_pkg::FUNC_ISSUE;
      else if (pick < 18) func = rrtt_pkg::FUNC_COMPLETE;
      else if (pick < 95) func = rrtt_pkg::FUNC_CHECK;
      else func = FUNC_UNUSED;
      adv = {$urandom, $urandom} % (step_max + 64'd1);
      traffic_time = traffic_time + adv[rrtt_pkg::NOW_W-1:0];
      pick = $urandom_range(99);
      if (pick < 5) now = traffic_time - rrtt_pkg::NOW_W'($urandom_range(0, 1000));
      else if (pick < 7) now = rrtt_pkg::NOW_W'({$urandom, $urandom});
      else now = traffic_time;
      send_request(func, id, now, $urandom_range(99) < 80);
    end
  endtask

  task automatic test_reset_defaults();
    logic [rrtt_pkg::CFG_W-1:0] rdata;
    cfg_base_timeout = rrtt_pkg::BASE_TIMEOUT_RST;
    cfg_max_timeout = rrtt_pkg::MAX_TIMEOUT_RST;
    cfg_max_retries = rrtt_pkg::MAX_RETRIES_RST;
    cfg_template_count = rrtt_pkg::TEMPLATE_COUNT_RST;
    apb_access(1'b0, {rrtt_pkg::REG_BASE_TIMEOUT, 2'b00}, '0, rdata);
    if (rdata !== rrtt_pkg::BASE_TIMEOUT_RST)
      report_mismatch("reset base_timeout", rdata, rrtt_pkg::BASE_TIMEOUT_RST);
    apb_access(1'b0, {rrtt_pkg::REG_MAX_TIMEOUT, 2'b00}, '0, rdata);
    if (rdata !== rrtt_pkg::MAX_TIMEOUT_RST)
      report_mismatch("reset max_timeout", rdata, rrtt_pkg::MAX_TIMEOUT_RST);
    apb_access(1'b0, {rrtt_pkg::REG_MAX_RETRIES, 2'b00}, '0, rdata);
    if (rdata !== {28'd0, rrtt_pkg::MAX_RETRIES_RST})
      report_mismatch("reset max_retries", rdata, rrtt_pkg::MAX_RETRIES_RST);
    apb_access(1'b0, {rrtt_pkg::REG_TEMPLATE_COUNT, 2'b00}, '0, rdata);
    if (rdata !== {21'd0, rrtt_pkg::TEMPLATE_COUNT_RST})
      report_mismatch("reset template_count", rdata, rrtt_pkg::TEMPLATE_COUNT_RST);
    send_request(rrtt_pkg::FUNC_ISSUE, 10'd3, 48'd0, 1'b1);
    send_request(rrtt_pkg::FUNC_CHECK, 10'd3, 48'd20000, 1'b1);
    wait_idle();
  endtask

  task automatic test_directed();
    set_config(32'd10, 32'd1000, 4'd1, 11'd7);
    send_request(rrtt_pkg::FUNC_ISSUE, 10'd0, 48'd100, 1'b1);
    send_request(rrtt_pkg::FUNC_CHECK, 10'd0, 48'd105, 1'b1);   // below limit
    send_request(rrtt_pkg::FUNC_CHECK, 10'd0, 48'd110, 1'b0);   // due, transmitter refuses
    send_request(rrtt_pkg::FUNC_CHECK, 10'd0, 48'd110, 1'b1);   // first resend
    send_request(rrtt_pkg::FUNC_CHECK, 10'd0, 48'd120, 1'b1);
    send_request(rrtt_pkg::FUNC_CHECK, 10'd0, 48'd130, 1'b1);   // limit doubled, not due
    send_request(rrtt_pkg::FUNC_CHECK, 10'd0, 48'd140, 1'b1);   // retries exhausted
    send_request(rrtt_pkg::FUNC_CHECK, 10'd0, 48'd5000, 1'b1);  // expired entry skipped
    send_request(rrtt_pkg::FUNC_COMPLETE, 10'd0, 48'd0, 1'b1);  // complete on expired entry
    send_request(rrtt_pkg::FUNC_ISSUE, 10'd1023, 48'hFFFF_FFFF_FFFF, 1'b0);  // drop
    send_request(rrtt_pkg::FUNC_CHECK, 10'd1023, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_request(rrtt_pkg::FUNC_ISSUE, 10'd5, 48'd1000, 1'b1);
    send_request(rrtt_pkg::FUNC_CHECK, 10'd5, 48'd500, 1'b1);   // clock behind start
    send_request(rrtt_pkg::FUNC_COMPLETE, 10'd5, 48'd0, 1'b0);
    send_request(rrtt_pkg::FUNC_CHECK, 10'd5, 48'd9000, 1'b1);  // done entry skipped
    send_request(rrtt_pkg::FUNC_CHECK, 10'd700, 48'd30, 1'b1);  // never issued entry
    send_request(FUNC_UNUSED, 10'h2AA, 48'hAAAA_AAAA_AAAA, 1'b1);
    send_request(rrtt_pkg::FUNC_ISSUE, 10'h155, 48'h5555_5555_5555, 1'b1);
    send_request(rrtt_pkg::FUNC_CHECK, 10'h155, 48'h5555_5555_555F, 1'b1);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    traffic_time = rrtt_pkg::NOW_W'({$urandom, $urandom}) & 48'h7FFF_FFFF_FFFF;
    set_config(32'd1, 32'd1, 4'd0, 11'd1);
    run_traffic(25, 64'd3);
    wait_idle();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 11'd1024);
    run_traffic(25, 64'h1_0000_0000);
    wait_idle();
    set_config(32'd0, 32'd5, 4'd7, 11'd0);       // zero template count
    run_traffic(25, 64'd10);
    wait_idle();
    set_config(32'd100, 32'hFFFF_FFFF, 4'd15, 11'd2047);
    run_traffic(25, 64'd3000);
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_config(32'd8, 32'd64, 4'd3, 11'd100);
    sink_hold = 300;
    src_idle_pct = 0;
    run_traffic(40, 64'd40);
    src_idle_pct = 31;
    wait_idle();
  endtask

  task automatic test_random();
    logic [31:0] base;
    for (int p = 0; p < 6; p++) begin
      base = $urandom_range(1, 64);
      set_config(base, base << $urandom_range(0, 6), 4'($urandom_range(0, 15)),
                 11'($urandom_range(1, 1024)));
      traffic_time = rrtt_pkg::NOW_W'({$urandom, $urandom}) & 48'h7FFF_FFFF_FFFF;
      src_idle_pct = (p == 2) ? 0 : 31;
      sink_idle_pct = (p == 2) ? 0 : 31;
      run_traffic(40, {32'd0, cfg_max_timeout} / 2 + 64'd1);
      wait_idle();
    end
    src_idle_pct = 31;
    sink_idle_pct = 31;
  endtask

  // result sink: random stalls, plus a long hold-off counted here
  initial begin
    table_result_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", {m_axis_tuser, m_axis_tdata}, 0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser !== want.action)
            report_mismatch("action", m_axis_tuser, want.action);
          if (m_axis_tdata[rrtt_pkg::ID_W-1:0] !== want.req_id)
            report_mismatch("id out", m_axis_tdata[rrtt_pkg::ID_W-1:0], want.req_id);
          if (m_axis_tdata[rrtt_pkg::OUT_TIDX_LSB +: rrtt_pkg::ID_W] !== want.template_index)
            report_mismatch("template_index",
                            m_axis_tdata[rrtt_pkg::OUT_TIDX_LSB +: rrtt_pkg::ID_W],
                            want.template_index);
          if (m_axis_tdata[rrtt_pkg::OUT_RETRY_LSB +: rrtt_pkg::RETRY_W] !== want.retries)
            report_mismatch("retries",
                            m_axis_tdata[rrtt_pkg::OUT_RETRY_LSB +: rrtt_pkg::RETRY_W],
                            want.retries);
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    for (int k = 0; k < rrtt_pkg::DEPTH_DEFAULT; k++) begin
      start_stamp[k] = '0;
      retry_tally[k] = '0;
      done_mark[k] = 1'b0;
      expired_mark[k] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/rrtt_pkg.sv
hw/rtl/rrtt_mod.sv
hw/rtl/request_retry_timeout_table.sv
hw/rtl/rrtt_chk.sv
bench/request_retry_timeout_table_tb.sv
